// File: rtl/mlqs_pkg.sv
package mlqs_pkg;

    localparam int MAX_PROCESSES = 128;
    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam int REC_W = 34;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_SJF  = 2'd1;
    localparam logic [1:0] CLASS_PRIO = 2'd2;
    localparam logic [1:0] CLASS_RR   = 2'd3;

    // phase code doubles as the queue number reported with a slot
    typedef enum logic [1:0] {
        PH_DONE = 2'd0,
        PH_Q1   = 2'd1,
        PH_Q2   = 2'd2,
        PH_Q3   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN
    } ctrl_state_t;

    typedef struct packed {
        logic load_en;
        logic clear_en;
        logic full_out;
        logic burst_step;
        logic scan_start;
        logic scan_run;
        logic commit;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   slots_nz;
        logic   full;
        logic   scan_done;
        logic   found;
    } dp_status_t;

endpackage

// File: rtl/mlqs_ram.sv
module mlqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/mlqs_ctrl.sv
module mlqs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           action,
    input  logic [1:0]           queue_class,
    input  mlqs_pkg::dp_status_t status,
    output mlqs_pkg::dp_cmd_t    cmd,
    output logic                 busy
);

    mlqs_pkg::ctrl_state_t state_reg, state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlqs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // decode requests and sequence the tick
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            mlqs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (action == mlqs_pkg::ACT_LOAD && queue_class != mlqs_pkg::CLASS_NONE)
                    begin
                        if (status.full)
                        begin
                            cmd.full_out = 1'b1;
                        end
                        else
                        begin
                            cmd.load_en = 1'b1;
                        end
                    end
                    else if (action == mlqs_pkg::ACT_CLEAR)
                    begin
                        cmd.clear_en = 1'b1;
                    end
                    else if (action == mlqs_pkg::ACT_TICK)
                    begin
                        state_next = mlqs_pkg::ST_TICK;
                    end
                end
            end
            mlqs_pkg::ST_TICK:
            begin
                if (status.phase == mlqs_pkg::PH_DONE)
                begin
                    cmd.advance = 1'b1;
                    state_next = mlqs_pkg::ST_IDLE;
                end
                else if (status.slots_nz)
                begin
                    cmd.burst_step = 1'b1;
                    state_next = mlqs_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next = mlqs_pkg::ST_SCAN;
                end
            end
            mlqs_pkg::ST_SCAN:
            begin
                if (!status.scan_done)
                begin
                    cmd.scan_run = 1'b1;
                end
                else if (status.found)
                begin
                    cmd.commit = 1'b1;
                    state_next = mlqs_pkg::ST_IDLE;
                end
                else
                begin
                    // queue exhausted: move on and retry within this tick, or end the schedule after queue three
                    cmd.advance = 1'b1;
                    if (status.phase == mlqs_pkg::PH_Q3)
                    begin
                        state_next = mlqs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mlqs_pkg::ST_TICK;
                    end
                end
            end
            default:
            begin
                state_next = mlqs_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != mlqs_pkg::ST_IDLE);

endmodule

// File: rtl/mlqs_datapath.sv
module mlqs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mlqs_pkg::dp_cmd_t    cmd,
    input  logic [1:0]           queue_class,
    input  logic [15:0]          process_id,
    input  logic [7:0]           priority_level,
    input  logic [7:0]           run_time,
    output mlqs_pkg::dp_status_t status,
    output logic                 result_valid,
    output logic [15:0]          slot_pid,
    output logic                 slot_valid,
    output logic                 burst_end,
    output logic [1:0]           queue_served,
    output logic                 all_done,
    output logic                 store_full
);

    localparam int IW = mlqs_pkg::IDX_W;
    localparam int CW = mlqs_pkg::CNT_W;

    // scheduler state
    logic [CW-1:0]    count_reg, count_next;
    mlqs_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]    cur_idx_reg, cur_idx_next;
    logic [7:0]       slots_reg, slots_next;
    logic [7:0]       level_reg, level_next;
    logic [15:0]      cur_id_reg, cur_id_next;
    logic [mlqs_pkg::MAX_PROCESSES-1:0] served_reg, served_next;

    // scan state
    logic [CW-1:0] k_reg, k_next;
    logic [IW-1:0] start_reg, start_next;
    logic          dv_reg, dv_next;
    logic [IW-1:0] didx_reg, didx_next;
    logic          best_v_reg, best_v_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [7:0]    best_key_reg, best_key_next;
    logic [15:0]   best_id_reg, best_id_next;
    logic [7:0]    best_rt_reg, best_rt_next;
    logic [7:0]    best_pri_reg, best_pri_next;
    logic [7:0]    best_prog_reg, best_prog_next;

    // result register
    logic        rv_reg, rv_next;
    logic [15:0] pid_reg, pid_next;
    logic        sv_reg, sv_next;
    logic        be_reg, be_next;
    logic [1:0]  qs_reg, qs_next;
    logic        ad_reg, ad_next;
    logic        sf_reg, sf_next;

    // memory ports
    logic                     rec_we;
    logic [mlqs_pkg::REC_W-1:0] rec_wdata, rec_q;
    logic                     prog_we;
    logic [IW-1:0]            prog_waddr;
    logic [7:0]               prog_wdata, prog_q;
    logic [IW-1:0]            rd_addr;

    // scan address and entry decode
    logic [CW:0]   idx_sum;
    logic [CW:0]   idx_wrap;
    logic [1:0]    e_class;
    logic [15:0]   e_id;
    logic [7:0]    e_pri;
    logic [7:0]    e_rt;
    logic [7:0]    e_key;
    logic          cand;
    logic [7:0]    slots_dec;
    logic [7:0]    rt_dec;

    mlqs_ram #(
        .WIDTH (mlqs_pkg::REC_W),
        .DEPTH (mlqs_pkg::MAX_PROCESSES)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (rec_wdata),
        .raddr (rd_addr),
        .rdata (rec_q)
    );

    mlqs_ram #(
        .WIDTH (8),
        .DEPTH (mlqs_pkg::MAX_PROCESSES)
    ) u_prog_ram (
        .clk   (clk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (prog_wdata),
        .raddr (rd_addr),
        .rdata (prog_q)
    );

    assign rec_we    = cmd.load_en;
    assign rec_wdata = {queue_class, process_id, priority_level, run_time};

    // progress is zeroed on load and bumped when queue three serves an entry
    assign prog_we    = cmd.load_en || (cmd.commit && phase_reg == mlqs_pkg::PH_Q3);
    assign prog_waddr = cmd.load_en ? count_reg[IW-1:0] : best_idx_reg;
    assign prog_wdata = cmd.load_en ? 8'd0 : best_prog_reg + 8'd1;

    // wrap the scan index round the record count
    assign idx_sum  = {1'b0, CW'(start_reg)} + {1'b0, k_reg};
    assign idx_wrap = (idx_sum >= {1'b0, count_reg}) ? idx_sum - {1'b0, count_reg} : idx_sum;
    assign rd_addr  = idx_wrap[IW-1:0];

    assign e_class = rec_q[33:32];
    assign e_id    = rec_q[31:16];
    assign e_pri   = rec_q[15:8];
    assign e_rt    = rec_q[7:0];
    assign e_key   = (phase_reg == mlqs_pkg::PH_Q1) ? e_rt : e_pri;

    // qualify the entry returned by the memory
    always_comb
    begin
        cand = 1'b0;
        case (phase_reg)
            mlqs_pkg::PH_Q1:
            begin
                cand = (e_class == mlqs_pkg::CLASS_SJF) && !served_reg[didx_reg];
            end
            mlqs_pkg::PH_Q2:
            begin
                cand = (e_class == mlqs_pkg::CLASS_PRIO) && !served_reg[didx_reg]
                    && (e_pri != 8'd0) && (e_pri >= level_reg);
            end
            mlqs_pkg::PH_Q3:
            begin
                cand = (e_class == mlqs_pkg::CLASS_RR) && (prog_q < e_rt);
            end
            default:
            begin
                cand = 1'b0;
            end
        endcase
    end

    assign slots_dec = slots_reg - 8'd1;
    assign rt_dec    = best_rt_reg - 8'd1;

    // next state for scheduler, scan and result
    always_comb
    begin
        count_next     = count_reg;
        phase_next     = phase_reg;
        cur_idx_next   = cur_idx_reg;
        slots_next     = slots_reg;
        level_next     = level_reg;
        cur_id_next    = cur_id_reg;
        served_next    = served_reg;
        k_next         = k_reg;
        start_next     = start_reg;
        dv_next        = 1'b0;
        didx_next      = didx_reg;
        best_v_next    = best_v_reg;
        best_idx_next  = best_idx_reg;
        best_key_next  = best_key_reg;
        best_id_next   = best_id_reg;
        best_rt_next   = best_rt_reg;
        best_pri_next  = best_pri_reg;
        best_prog_next = best_prog_reg;
        rv_next = 1'b0;
        pid_next = 16'd0;
        sv_next = 1'b0;
        be_next = 1'b0;
        qs_next = 2'd0;
        ad_next = 1'b0;
        sf_next = 1'b0;

        if (cmd.load_en)
        begin
            served_next[count_reg[IW-1:0]] = 1'b0;
            count_next = count_reg + CW'(1);
        end

        if (cmd.full_out)
        begin
            rv_next = 1'b1;
            sf_next = 1'b1;
        end

        if (cmd.clear_en)
        begin
            count_next   = '0;
            phase_next   = mlqs_pkg::PH_Q1;
            cur_idx_next = '0;
            slots_next   = 8'd0;
            level_next   = 8'd1;
            served_next  = '0;
        end

        // continue the running burst
        if (cmd.burst_step)
        begin
            slots_next = slots_dec;
            rv_next  = 1'b1;
            pid_next = cur_id_reg;
            sv_next  = 1'b1;
            be_next  = (slots_dec == 8'd0);
            qs_next  = phase_reg;
        end

        if (cmd.scan_start)
        begin
            k_next      = '0;
            best_v_next = 1'b0;
            start_next  = '0;
            if (phase_reg == mlqs_pkg::PH_Q3 && cur_idx_reg < count_reg)
            begin
                start_next = cur_idx_reg[IW-1:0];
            end
        end

        if (cmd.scan_run)
        begin
            // issue the next address
            if (k_reg < count_reg)
            begin
                k_next    = k_reg + CW'(1);
                dv_next   = 1'b1;
                didx_next = rd_addr;
            end
            // judge the entry read last cycle
            if (dv_reg && cand)
            begin
                if (!best_v_reg || (phase_reg != mlqs_pkg::PH_Q3 && e_key < best_key_reg))
                begin
                    best_v_next    = 1'b1;
                    best_idx_next  = didx_reg;
                    best_key_next  = e_key;
                    best_id_next   = e_id;
                    best_rt_next   = e_rt;
                    best_pri_next  = e_pri;
                    best_prog_next = prog_q;
                end
            end
        end

        if (cmd.commit)
        begin
            rv_next = 1'b1;
            qs_next = phase_reg;
            if (phase_reg == mlqs_pkg::PH_Q3)
            begin
                cur_idx_next = CW'(best_idx_reg) + CW'(1);
                pid_next = best_id_reg;
                sv_next  = 1'b1;
                be_next  = 1'b1;
            end
            else
            begin
                served_next[best_idx_reg] = 1'b1;
                cur_idx_next = CW'(best_idx_reg);
                cur_id_next  = best_id_reg;
                if (phase_reg == mlqs_pkg::PH_Q2)
                begin
                    level_next = best_pri_reg;
                end
                if (best_rt_reg == 8'd0)
                begin
                    // empty burst
                    slots_next = 8'd0;
                    be_next    = 1'b1;
                end
                else
                begin
                    slots_next = rt_dec;
                    pid_next   = best_id_reg;
                    sv_next    = 1'b1;
                    be_next    = (rt_dec == 8'd0);
                end
            end
        end

        // step to the next queue; leaving queue three ends the schedule
        if (cmd.advance)
        begin
            case (phase_reg)
                mlqs_pkg::PH_Q1:
                begin
                    phase_next = mlqs_pkg::PH_Q2;
                end
                mlqs_pkg::PH_Q2:
                begin
                    phase_next   = mlqs_pkg::PH_Q3;
                    cur_idx_next = '0;
                end
                mlqs_pkg::PH_Q3:
                begin
                    phase_next = mlqs_pkg::PH_DONE;
                    rv_next = 1'b1;
                    ad_next = 1'b1;
                end
                default:
                begin
                    rv_next = 1'b1;
                    ad_next = 1'b1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            phase_reg   <= mlqs_pkg::PH_Q1;
            cur_idx_reg <= '0;
            slots_reg   <= 8'd0;
            level_reg   <= 8'd1;
            served_reg  <= '0;
            k_reg       <= '0;
            dv_reg      <= 1'b0;
            best_v_reg  <= 1'b0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            cur_idx_reg <= cur_idx_next;
            slots_reg   <= slots_next;
            level_reg   <= level_next;
            served_reg  <= served_next;
            k_reg       <= k_next;
            dv_reg      <= dv_next;
            best_v_reg  <= best_v_next;
            rv_reg      <= rv_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_id_reg    <= cur_id_next;
        start_reg     <= start_next;
        didx_reg      <= didx_next;
        best_idx_reg  <= best_idx_next;
        best_key_reg  <= best_key_next;
        best_id_reg   <= best_id_next;
        best_rt_reg   <= best_rt_next;
        best_pri_reg  <= best_pri_next;
        best_prog_reg <= best_prog_next;
        pid_reg <= pid_next;
        sv_reg  <= sv_next;
        be_reg  <= be_next;
        qs_reg  <= qs_next;
        ad_reg  <= ad_next;
        sf_reg  <= sf_next;
    end

    assign status.phase     = phase_reg;
    assign status.slots_nz  = (slots_reg != 8'd0);
    assign status.full      = (count_reg >= CW'(mlqs_pkg::MAX_PROCESSES));
    assign status.scan_done = (k_reg >= count_reg) && !dv_reg;
    assign status.found     = best_v_reg;

    assign result_valid = rv_reg;
    assign slot_pid     = pid_reg;
    assign slot_valid   = sv_reg;
    assign burst_end    = be_reg;
    assign queue_served = qs_reg;
    assign all_done     = ad_reg;
    assign store_full   = sf_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (CW'(didx_reg) < count_reg))
        else $error("scan index beyond record count");

    a_burst_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (slots_reg != 8'd0) |-> (phase_reg == mlqs_pkg::PH_Q1 || phase_reg == mlqs_pkg::PH_Q2))
        else $error("burst pending outside queues one and two");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(mlqs_pkg::MAX_PROCESSES))
        else $error("record count overflow");

endmodule

// File: rtl/multilevel_queue_scheduler_core.sv
// Channel  | Handshake                   | Payload
// request  | start (in), busy (out)      | action, queue_class, process_id,
//          |                             | priority_level, run_time
// result   | result_valid (out, 1 cycle) | slot_pid, slot_valid, burst_end,
//          |                             | queue_served, all_done, store_full
//
// Load, clear and ignored requests are handled in idle; busy stays low.
// A tick continuing a burst, or one after the schedule is done, raises busy for ST_TICK only.
// A tick that scans the record store reads every record once per queue visited
// (one memory read per cycle), up to three scans when queues run empty.
// The result is valid for one cycle; for a tick it starts at the edge that drops busy.
// Reset clears all control state; the record memories need no clearing pass.
// The receiver cannot stall results.
module multilevel_queue_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [1:0]  queue_class,
    input  logic [15:0] process_id,
    input  logic [7:0]  priority_level,
    input  logic [7:0]  run_time,
    output logic        result_valid,
    output logic [15:0] slot_pid,
    output logic        slot_valid,
    output logic        burst_end,
    output logic [1:0]  queue_served,
    output logic        all_done,
    output logic        store_full
);

    mlqs_pkg::dp_cmd_t    cmd;
    mlqs_pkg::dp_status_t status;

    mlqs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .queue_class (queue_class),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy)
    );

    mlqs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .queue_class    (queue_class),
        .process_id     (process_id),
        .priority_level (priority_level),
        .run_time       (run_time),
        .status         (status),
        .result_valid   (result_valid),
        .slot_pid       (slot_pid),
        .slot_valid     (slot_valid),
        .burst_end      (burst_end),
        .queue_served   (queue_served),
        .all_done       (all_done),
        .store_full     (store_full)
    );

endmodule

// File: verif/tb_top.sv
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [1:0]  queue_class;
    logic [15:0] process_id;
    logic [7:0]  priority_level;
    logic [7:0]  run_time;
    logic        result_valid;
    logic [15:0] slot_pid;
    logic        slot_valid;
    logic        burst_end;
    logic [1:0]  queue_served;
    logic        all_done;
    logic        store_full;

    localparam logic [1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]  act;
        logic [1:0]  cls;
        logic [15:0] pid;
        logic [7:0]  pri;
        logic [7:0]  rt;
    } request_t;

    typedef struct packed {
        logic [15:0] pid;
        logic        valid;
        logic        bend;
        logic [1:0]  queue;
        logic        done;
        logic        full;
    } slot_t;

    request_t pending_requests[$];
    slot_t    expected_slots[$];
    int       error_count;
    int       tick_count;
    int       slot_count;
    bit       stimulus_done;

    // scheduler shadow state
    logic [1:0]  sh_cls[mlqs_pkg::MAX_PROCESSES];
    logic [15:0] sh_pid[mlqs_pkg::MAX_PROCESSES];
    logic [7:0]  sh_pri[mlqs_pkg::MAX_PROCESSES];
    logic [7:0]  sh_rt[mlqs_pkg::MAX_PROCESSES];
    logic [7:0]  sh_progress[mlqs_pkg::MAX_PROCESSES];
    bit          sh_served[mlqs_pkg::MAX_PROCESSES];
    int          sh_count;
    mlqs_pkg::phase_t sh_phase;
    int          sh_index;
    int          sh_left;
    int          sh_level;

    multilevel_queue_scheduler_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void clear_schedule();
        for (int i = 0; i < mlqs_pkg::MAX_PROCESSES; i++)
        begin
            sh_progress[i] = '0;
            sh_served[i] = 1'b0;
        end
        sh_count = 0;
        sh_phase = mlqs_pkg::PH_Q1;
        sh_index = 0;
        sh_left = 0;
        sh_level = 1;
    endfunction

    // find next unserved record of queue one or two, -1 when none
    function automatic int pick_job(input mlqs_pkg::phase_t q);
        int best;
        int key;
        int k;
        best = -1;
        key = 0;
        for (int i = 0; i < sh_count; i++)
        begin
            if (sh_cls[i] != 2'(q) || sh_served[i])
                continue;
            if (q == mlqs_pkg::PH_Q1)
                k = sh_rt[i];
            else
            begin
                k = sh_pri[i];
                if (k == 0 || k < sh_level)
                    continue;
            end
            if (best < 0 || k < key)
            begin
                best = i;
                key = k;
            end
        end
        return best;
    endfunction

    // advance the schedule by one slot
    function automatic slot_t schedule_tick();
        slot_t s;
        int sel;
        int n;
        int who;
        int first;
        int i;
        s = '0;
        for (int round = 0; round < 5; round++)
        begin
            if (sh_phase == mlqs_pkg::PH_Q1 || sh_phase == mlqs_pkg::PH_Q2)
            begin
                if (sh_left == 0)
                begin
                    sel = pick_job(sh_phase);
                    if (sel < 0)
                    begin
                        if (sh_phase == mlqs_pkg::PH_Q2)
                            sh_index = 0;
                        sh_phase = mlqs_pkg::phase_t'(sh_phase + 1);
                        continue;
                    end
                    sh_index = sel;
                    sh_served[sel] = 1'b1;
                    if (sh_phase == mlqs_pkg::PH_Q2)
                        sh_level = sh_pri[sel];
                    sh_left = sh_rt[sel];
                    if (sh_left == 0)
                    begin
                        s.bend = 1'b1;
                        s.queue = sh_phase;
                        return s;
                    end
                end
                sh_left--;
                s.pid = sh_pid[sh_index];
                s.valid = 1'b1;
                s.bend = (sh_left == 0);
                s.queue = sh_phase;
                return s;
            end
            if (sh_phase == mlqs_pkg::PH_Q3)
            begin
                n = sh_count;
                who = -1;
                first = (sh_index < n) ? sh_index : 0;
                for (int k = 0; k < n && who < 0; k++)
                begin
                    i = first + k;
                    if (i >= n)
                        i -= n;
                    if (sh_cls[i] == mlqs_pkg::CLASS_RR && sh_progress[i] < sh_rt[i])
                        who = i;
                end
                if (who < 0)
                begin
                    sh_phase = mlqs_pkg::PH_DONE;
                    continue;
                end
                sh_progress[who]++;
                sh_index = who + 1;
                s.pid = sh_pid[who];
                s.valid = 1'b1;
                s.bend = 1'b1;
                s.queue = mlqs_pkg::PH_Q3;
                return s;
            end
            s.done = 1'b1;
            return s;
        end
        s.done = 1'b1;
        return s;
    endfunction

    // work out the result a request causes, if any
    function automatic void predict_request(input request_t r);
        slot_t s;
        s = '0;
        case (r.act)
            mlqs_pkg::ACT_LOAD:
            begin
                if (r.cls == mlqs_pkg::CLASS_NONE)
                    return;
                if (sh_count >= mlqs_pkg::MAX_PROCESSES)
                begin
                    s.full = 1'b1;
                    expected_slots.push_back(s);
                    return;
                end
                sh_cls[sh_count] = r.cls;
                sh_pid[sh_count] = r.pid;
                sh_pri[sh_count] = r.pri;
                sh_rt[sh_count] = r.rt;
                sh_progress[sh_count] = '0;
                sh_served[sh_count] = 1'b0;
                sh_count++;
            end
            mlqs_pkg::ACT_CLEAR: clear_schedule();
            mlqs_pkg::ACT_TICK:
            begin
                expected_slots.push_back(schedule_tick());
                tick_count++;
            end
            default: ;
        endcase
    endfunction

    function automatic request_t make_req(input logic [1:0] a, input logic [1:0] c,
                                          input int p, input int pr, input int t);
        request_t r;
        r.act = a;
        r.cls = c;
        r.pid = 16'(p);
        r.pri = 8'(pr);
        r.rt = 8'(t);
        return r;
    endfunction

    function automatic request_t rand_load(input int max_rt);
        return make_req(mlqs_pkg::ACT_LOAD, 2'($urandom_range(1, 3)), $urandom,
                        ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255),
                        ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, max_rt));
    endfunction

    // fill the request queue
    initial
    begin
        int nrec;
        int total;
        int max_rt;
        // directed: all classes, extremes, empty bursts, ignored items
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_NONE,
            16'hFFFF, 255, 255));
        pending_requests.push_back(make_req(ACT_NOP, mlqs_pkg::CLASS_SJF, 16'h5555, 3, 3));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_SJF,
            16'hFFFF, 255, 2));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_SJF,
            16'h0000, 0, 0));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_SJF,
            16'hAAAA, 1, 2));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_PRIO,
            16'h5555, 0, 1));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_PRIO,
            16'h1234, 255, 1));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_PRIO,
            16'h4321, 1, 0));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_RR,
            16'h00FF, 7, 2));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_RR,
            16'hFF00, 7, 0));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_RR,
            16'h0F0F, 7, 1));
        for (int i = 0; i < 12; i++)
            pending_requests.push_back(make_req(mlqs_pkg::ACT_TICK, mlqs_pkg::CLASS_NONE,
                0, 0, 0));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_LOAD, mlqs_pkg::CLASS_SJF,
            16'h7777, 9, 1));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_TICK, mlqs_pkg::CLASS_NONE,
            0, 0, 0));
        pending_requests.push_back(make_req(mlqs_pkg::ACT_CLEAR, mlqs_pkg::CLASS_NONE,
            0, 0, 0));
        // random: mostly load-then-tick sessions, with noise and a store overflow
        total = 0;
        while (total < 1800)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                nrec = mlqs_pkg::MAX_PROCESSES + 2;
                max_rt = 1;
            end
            else
            begin
                nrec = $urandom_range(1, 12);
                max_rt = 4;
            end
            for (int i = 0; i < nrec; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    pending_requests.push_back(make_req(2'($urandom_range(0, 3)),
                        2'($urandom), $urandom, $urandom, $urandom));
                else
                    pending_requests.push_back(rand_load(max_rt));
                total++;
            end
            for (int i = 0; i < nrec * 3 + 2 && i < 60; i++)
            begin
                if ($urandom_range(0, 14) == 0)
                    pending_requests.push_back(rand_load(max_rt));
                else
                    pending_requests.push_back(make_req(mlqs_pkg::ACT_TICK, 2'($urandom),
                        $urandom, $urandom, $urandom));
                total++;
            end
            pending_requests.push_back(make_req(mlqs_pkg::ACT_CLEAR, 2'($urandom),
                $urandom, $urandom, $urandom));
            total++;
        end
    end

    // reset and release
    initial
    begin
        error_count = 0;
        tick_count = 0;
        slot_count = 0;
        stimulus_done = 1'b0;
        clear_schedule();
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // drive requests with a random gap before each
    int gap_left;
    initial gap_left = 0;
    initial
    begin
        start = 1'b0;
        action = ACT_NOP;
        queue_class = mlqs_pkg::CLASS_NONE;
        process_id = '0;
        priority_level = '0;
        run_time = '0;
    end

    always @(posedge clk)
    begin
        request_t r;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_request({action, queue_class, process_id, priority_level, run_time});
                void'(pending_requests.pop_front());
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            if (start && busy)
                ;
            else if (gap_left > 0 || pending_requests.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
                if (pending_requests.size() == 0)
                    stimulus_done = 1'b1;
            end
            else
            begin
                r = pending_requests[0];
                start <= 1'b1;
                action <= r.act;
                queue_class <= r.cls;
                process_id <= r.pid;
                priority_level <= r.pri;
                run_time <= r.rt;
            end
        end
    end

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        slot_t want;
        if (rst_n && result_valid)
        begin
            slot_count++;
            if (expected_slots.size() == 0)
                report_mismatch("unexpected result, pid", slot_pid, -1);
            else
            begin
                want = expected_slots.pop_front();
                if (slot_pid !== want.pid)
                    report_mismatch("slot_pid", slot_pid, want.pid);
                if (slot_valid !== want.valid)
                    report_mismatch("slot_valid", slot_valid, want.valid);
                if (burst_end !== want.bend)
                    report_mismatch("burst_end", burst_end, want.bend);
                if (queue_served !== want.queue)
                    report_mismatch("queue_served", queue_served, want.queue);
                if (all_done !== want.done)
                    report_mismatch("all_done", all_done, want.done);
                if (store_full !== want.full)
                    report_mismatch("store_full", store_full, want.full);
            end
        end
    end

    // finish once drained
    initial
    begin
        wait (stimulus_done);
        wait (expected_slots.size() == 0);
        repeat (3 * (mlqs_pkg::MAX_PROCESSES + 4) + 20) @(posedge clk);
        if (expected_slots.size() != 0)
            report_mismatch("results left over", expected_slots.size(), 0);
        $display("Ran %0d ticks and checked %0d results across SJF, priority,", tick_count,
                 slot_count);
        $display("round-robin, empty bursts, late loads, full store and clears.");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
